FILE: rtl/ett_pkg.sv
// ---------------------------------------------------------------------------
// ett_pkg
// Shared types and constants of the template tag tokenizer.
// ---------------------------------------------------------------------------
package ett_pkg;

    localparam int TOKEN_LINE_W = 24;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    // characters the parser looks for
    localparam logic [7:0] CH_LT  = 8'h3C;
    localparam logic [7:0] CH_PCT = 8'h25;
    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_NL  = 8'h0A;

    // token and block kinds
    localparam logic [1:0] KIND_LIT    = 2'd0;
    localparam logic [1:0] KIND_CODE   = 2'd1;
    localparam logic [1:0] KIND_EXPR   = 2'd2;
    localparam logic [1:0] KIND_PCTLIT = 2'd3;

    typedef enum logic [4:0] {
        ST_TEXT      = 5'b00001,
        ST_OPEN      = 5'b00010,
        ST_OPEN_PCT  = 5'b00100,
        ST_BLOCK     = 5'b01000,
        ST_CLOSE_PCT = 5'b10000
    } parse_state_t;

    // one result of an item, without its line and run marker
    typedef struct packed {
        logic       has;
        logic [7:0] data;
        logic [1:0] kind;
        logic       tok_end;
    } res_slot_t;

    // everything one item causes: up to three results sharing one line
    typedef struct packed {
        logic [1:0]                cnt;
        logic [TOKEN_LINE_W-1:0]   line;
        res_slot_t [2:0]           slot;
    } res_cmd_t;

    function automatic res_slot_t make_slot(logic has, logic [7:0] data,
                                            logic [1:0] kind, logic tok_end);
        res_slot_t s;
        s.has     = has;
        s.data    = data;
        s.kind    = kind;
        s.tok_end = tok_end;
        return s;
    endfunction

endpackage

FILE: rtl/erb_template_tokenizer_top.sv
// ---------------------------------------------------------------------------
// erb_template_tokenizer_top
// Streaming tokenizer for template text with code and expression tags.
// ---------------------------------------------------------------------------
// An input item is taken every cycle as long as the four-entry command queue
// between the parser and the result sequencer has room. Each item gives zero
// to three results; the sequencer puts out one result per cycle while the
// output is ready, so an item with two or three results (a pending '<'
// resolved, a block opened) holds the output side for each of its results,
// and a run of such items fills the queue and stalls the input. An input
// item is written into the queue, and its first result then into the output
// register. Line numbers are kept at LINE_BITS and shown as the low 24 bits.
module erb_template_tokenizer_top
    import ett_pkg::*;
#(
    parameter int LINE_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] out_byte, [31:8] token_line, [32] run_last
    output logic [2:0]  m_tuser,   // [0] has_byte, [2:1] token_kind
    output logic        m_tlast    // token_end
);

    logic                    fire;
    logic                    push;
    res_cmd_t                cmd;
    logic                    q_not_full;
    logic                    q_not_empty;
    logic                    pop;
    res_cmd_t                head;
    res_slot_t               out_slot;
    logic [TOKEN_LINE_W-1:0] out_line;
    logic                    out_run_last;

    assign s_tready = q_not_full;
    assign fire     = s_tvalid && s_tready;

    ett_front #(
        .LINE_BITS(LINE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .action    (s_tuser),
        .byte_value(s_tdata),
        .push      (push),
        .cmd       (cmd)
    );

    ett_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (cmd),
        .not_full (q_not_full),
        .pop      (pop),
        .not_empty(q_not_empty),
        .head     (head)
    );

    ett_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_not_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_slot    (out_slot),
        .out_line    (out_line),
        .out_run_last(out_run_last)
    );

    assign m_tdata = {7'd0, out_run_last, out_line, out_slot.data};
    assign m_tuser = {out_slot.kind, out_slot.has};
    assign m_tlast = out_slot.tok_end;

endmodule

FILE: rtl/ett_front.sv
// ---------------------------------------------------------------------------
// ett_front
// Parser state machine: classifies each input item into a result command.
// ---------------------------------------------------------------------------
module ett_front
    import ett_pkg::*;
#(
    parameter int LINE_BITS = 24
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  logic     action,
    input  logic [7:0] byte_value,
    output logic     push,
    output res_cmd_t cmd
);

    parse_state_t         state_reg, state_next;
    logic [1:0]           kind_reg, kind_next;
    logic [LINE_BITS-1:0] lc_reg, lc_next;
    logic [LINE_BITS-1:0] tsl_reg, tsl_next;
    logic                 ne_reg, ne_next;
    logic [1:0]           okind;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        lc_next    = lc_reg;
        tsl_next   = tsl_reg;
        ne_next    = ne_reg;
        cmd        = '0;
        cmd.line   = TOKEN_LINE_W'(tsl_reg);
        okind      = (kind_reg == KIND_PCTLIT) ? KIND_LIT : kind_reg;

        if (action)
        begin
            if (ne_reg)
            begin
                cmd.cnt     = 2'd1;
                cmd.slot[0] = make_slot(1'b0, 8'h00, KIND_LIT, 1'b1);
            end
            state_next = ST_TEXT;
            kind_next  = KIND_CODE;
            ne_next    = 1'b0;
        end
        else
        begin
            // saturating line counter
            if (byte_value == CH_NL && lc_reg != {LINE_BITS{1'b1}})
                lc_next = lc_reg + 1'b1;

            unique case (state_reg)
                ST_OPEN:
                begin
                    // a second '<' gives one '<' and keeps the next one pending
                    if (byte_value == CH_LT)
                    begin
                        cmd.cnt     = 2'd1;
                        cmd.slot[0] = make_slot(1'b1, CH_LT, KIND_LIT, 1'b0);
                        ne_next     = 1'b1;
                    end
                    else if (byte_value == CH_PCT)
                    begin
                        state_next = ST_OPEN_PCT;
                        tsl_next   = lc_next;
                    end
                    else
                    begin
                        cmd.cnt     = 2'd2;
                        cmd.slot[0] = make_slot(1'b1, CH_LT, KIND_LIT, 1'b0);
                        cmd.slot[1] = make_slot(1'b1, byte_value, KIND_LIT, 1'b0);
                        ne_next     = 1'b1;
                        state_next  = ST_TEXT;
                    end
                end
                ST_OPEN_PCT:
                begin
                    // opening a block always ends the literal token
                    cmd.slot[0] = make_slot(1'b0, 8'h00, KIND_LIT, 1'b1);
                    state_next  = ST_BLOCK;
                    if (byte_value == CH_EQ)
                    begin
                        cmd.cnt   = 2'd1;
                        kind_next = KIND_EXPR;
                        ne_next   = 1'b0;
                    end
                    else if (byte_value == CH_PCT)
                    begin
                        cmd.cnt     = 2'd3;
                        cmd.slot[1] = make_slot(1'b1, CH_LT, KIND_LIT, 1'b0);
                        cmd.slot[2] = make_slot(1'b1, CH_PCT, KIND_LIT, 1'b0);
                        kind_next   = KIND_PCTLIT;
                        ne_next     = 1'b1;
                    end
                    else
                    begin
                        cmd.cnt     = 2'd2;
                        cmd.slot[1] = make_slot(1'b1, byte_value, KIND_CODE, 1'b0);
                        kind_next   = KIND_CODE;
                        ne_next     = 1'b1;
                    end
                end
                ST_BLOCK:
                begin
                    if (byte_value == CH_PCT)
                        state_next = ST_CLOSE_PCT;
                    else
                    begin
                        cmd.cnt     = 2'd1;
                        cmd.slot[0] = make_slot(1'b1, byte_value, okind, 1'b0);
                        ne_next     = 1'b1;
                    end
                end
                ST_CLOSE_PCT:
                begin
                    // "%%" gives one '%' and keeps the next '%' pending
                    if (byte_value == CH_PCT)
                    begin
                        cmd.cnt     = 2'd1;
                        cmd.slot[0] = make_slot(1'b1, CH_PCT, okind, 1'b0);
                        ne_next     = 1'b1;
                    end
                    else if (byte_value == CH_GT)
                    begin
                        cmd.cnt = 2'd1;
                        if (kind_reg == KIND_PCTLIT)
                            cmd.slot[0] = make_slot(1'b1, CH_GT, KIND_LIT, 1'b1);
                        else
                            cmd.slot[0] = make_slot(1'b0, 8'h00, kind_reg, 1'b1);
                        ne_next    = 1'b0;
                        state_next = ST_TEXT;
                        tsl_next   = lc_next;
                    end
                    else
                    begin
                        cmd.cnt     = 2'd2;
                        cmd.slot[0] = make_slot(1'b1, CH_PCT, okind, 1'b0);
                        cmd.slot[1] = make_slot(1'b1, byte_value, okind, 1'b0);
                        ne_next     = 1'b1;
                        state_next  = ST_BLOCK;
                    end
                end
                default:
                begin
                    state_next = ST_TEXT;
                    if (byte_value == CH_LT)
                        state_next = ST_OPEN;
                    else
                    begin
                        cmd.cnt     = 2'd1;
                        cmd.slot[0] = make_slot(1'b1, byte_value, KIND_LIT, 1'b0);
                        ne_next     = 1'b1;
                    end
                end
            endcase
        end
    end

    assign push = fire && (cmd.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_TEXT;
            kind_reg  <= KIND_CODE;
            lc_reg    <= LINE_BITS'(1);
            tsl_reg   <= LINE_BITS'(1);
            ne_reg    <= 1'b0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            lc_reg    <= lc_next;
            tsl_reg   <= tsl_next;
            ne_reg    <= ne_next;
        end
    end

endmodule

FILE: rtl/ett_queue.sv
// ---------------------------------------------------------------------------
// ett_queue
// Small command queue between the parser and the result sequencer.
// ---------------------------------------------------------------------------
module ett_queue
    import ett_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  res_cmd_t push_cmd,
    output logic     not_full,
    input  logic     pop,
    output logic     not_empty,
    output res_cmd_t head
);

    res_cmd_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign not_full  = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/ett_back.sv
// ---------------------------------------------------------------------------
// ett_back
// Result sequencer: walks the results of each command into the output register.
// ---------------------------------------------------------------------------
module ett_back
    import ett_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  res_cmd_t                head,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output res_slot_t               out_slot,
    output logic [TOKEN_LINE_W-1:0] out_line,
    output logic                    out_run_last
);

    logic [1:0]              idx_reg;
    logic                    valid_reg;
    res_slot_t               slot_reg;
    logic [TOKEN_LINE_W-1:0] line_reg;
    logic                    run_last_reg;
    logic                    load;
    logic                    at_last;

    assign load    = q_valid && (!valid_reg || out_ready);
    assign at_last = (idx_reg == head.cnt - 2'd1);
    assign pop     = load && at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= at_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg     <= head.slot[idx_reg];
            line_reg     <= head.line;
            run_last_reg <= at_last;
        end
    end

    assign out_valid    = valid_reg;
    assign out_slot     = slot_reg;
    assign out_line     = line_reg;
    assign out_run_last = run_last_reg;

endmodule

FILE: rtl/ett_checker.sv
// ---------------------------------------------------------------------------
// ett_checker
// Port-level checks of the tokenizer output stream.
// ---------------------------------------------------------------------------
module ett_checker
    import ett_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("output changed while stalled");

    // a result without a byte only ever ends a token
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("empty result that does not end a token");

    // the escaped-block kind never leaves the block
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[2:1] != KIND_PCTLIT)
        else $error("bad token kind");

    // only the closing '>' of an escaped block ends a token with a byte
    a_byte_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && m_tuser[0] |->
        m_tuser[2:1] == KIND_LIT && m_tdata[7:0] == CH_GT && m_tdata[32])
        else $error("token ends on a byte other than the escaped close");

endmodule

bind erb_template_tokenizer_top ett_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);

FILE: bench/erb_template_tokenizer_top_test.sv
// ---------------------------------------------------------------------------
// erb_template_tokenizer_top_test
// Self-checking bench for the streaming template tag tokenizer: directed
// escapes and tag openings first, then random well-formed templates mixed
// with noise under varying stream backpressure. A scoreboard tracks the
// parser state, predicts every token result and compares it on transfer.
// ---------------------------------------------------------------------------
module erb_template_tokenizer_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ett_pkg::*;

    // narrow line counter, below the shown token_line width
    localparam int LINE_W     = 8;
    localparam int FLUSH_ITEM = -1;

    typedef struct packed {
        logic                    has;
        logic [7:0]              data;
        logic [1:0]              kind;
        logic                    tok_end;
        logic [TOKEN_LINE_W-1:0] line;
        logic                    last;
    } token_result_t;

    class tokenizer_scoreboard;
        parse_state_t      state;
        logic [1:0]        blk;
        logic [LINE_W-1:0] line_cnt;
        logic [LINE_W-1:0] start_line;
        bit                nonempty;
        token_result_t     expected_q[$];
        int                errors;
        int                checked;

        function new();
            state      = ST_TEXT;
            blk        = KIND_CODE;
            line_cnt   = LINE_W'(1);
            start_line = LINE_W'(1);
            nonempty   = 1'b0;
            errors     = 0;
            checked    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_result(logic has, logic [7:0] data, logic [1:0] kind,
                                  logic tok_end);
            token_result_t r;
            r.has      = has;
            r.data     = data;
            r.kind     = kind;
            r.tok_end  = tok_end;
            r.line     = TOKEN_LINE_W'(start_line);
            r.last     = 1'b0;
            expected_q = {expected_q, r};
        endfunction

        function void push_byte(logic [7:0] data, logic [1:0] kind);
            push_result(1'b1, data, kind, 1'b0);
            nonempty = 1'b1;
        endfunction

        // a "<%%" block streams out as literal text
        function logic [1:0] shown_kind();
            return (blk == KIND_PCTLIT) ? KIND_LIT : blk;
        endfunction

        function void note_input(logic act, logic [7:0] b);
            int            first;
            token_result_t r;
            first = expected_q.size();
            if (act)
            begin
                if (nonempty)
                    push_result(1'b0, 8'h00, KIND_LIT, 1'b1);
                state    = ST_TEXT;
                blk      = KIND_CODE;
                nonempty = 1'b0;
            end
            else
            begin
                if (b == CH_NL && line_cnt != {LINE_W{1'b1}})
                    line_cnt++;
                case (state)
                    ST_OPEN:
                    begin
                        if (b == CH_LT)
                        begin
                            push_byte(CH_LT, KIND_LIT);
                        end
                        else if (b == CH_PCT)
                        begin
                            state      = ST_OPEN_PCT;
                            start_line = line_cnt;
                        end
                        else
                        begin
                            push_byte(CH_LT, KIND_LIT);
                            push_byte(b, KIND_LIT);
                            state = ST_TEXT;
                        end
                    end
                    ST_OPEN_PCT:
                    begin
                        // opening a tag always closes the literal token
                        push_result(1'b0, 8'h00, KIND_LIT, 1'b1);
                        nonempty = 1'b0;
                        if (b == CH_EQ)
                        begin
                            blk = KIND_EXPR;
                        end
                        else if (b == CH_PCT)
                        begin
                            blk = KIND_PCTLIT;
                            push_byte(CH_LT, KIND_LIT);
                            push_byte(CH_PCT, KIND_LIT);
                        end
                        else
                        begin
                            blk = KIND_CODE;
                            push_byte(b, KIND_CODE);
                        end
                        state = ST_BLOCK;
                    end
                    ST_BLOCK:
                    begin
                        if (b == CH_PCT)
                            state = ST_CLOSE_PCT;
                        else
                            push_byte(b, shown_kind());
                    end
                    ST_CLOSE_PCT:
                    begin
                        if (b == CH_PCT)
                        begin
                            push_byte(CH_PCT, shown_kind());
                        end
                        else if (b == CH_GT)
                        begin
                            if (blk == KIND_PCTLIT)
                                push_result(1'b1, CH_GT, KIND_LIT, 1'b1);
                            else
                                push_result(1'b0, 8'h00, blk, 1'b1);
                            nonempty   = 1'b0;
                            state      = ST_TEXT;
                            start_line = line_cnt;
                        end
                        else
                        begin
                            push_byte(CH_PCT, shown_kind());
                            push_byte(b, shown_kind());
                            state = ST_BLOCK;
                        end
                    end
                    default:
                    begin
                        state = ST_TEXT;
                        if (b == CH_LT)
                            state = ST_OPEN;
                        else
                            push_byte(b, KIND_LIT);
                    end
                endcase
            end
            if (expected_q.size() > first)
            begin
                r      = expected_q[expected_q.size() - 1];
                r.last = 1'b1;
                expected_q[expected_q.size() - 1] = r;
            end
        endfunction

        function void report_mismatch(string msg);
            errors++;
            if (errors <= 10)
                $display("%0t: %s", $realtime, msg);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
                report_mismatch($sformatf("result %0d: %s expected %0h got %0h",
                                          checked, name, want, got));
        endfunction

        function void check_result(token_result_t got);
            token_result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result: has=%0b byte=%02h kind=%0d end=%0b",
                                          got.has, got.data, got.kind, got.tok_end));
                return;
            end
            want = expected_q.pop_front();
            compare_field("has_byte", want.has, got.has);
            compare_field("out_byte", want.data, got.data);
            compare_field("token_kind", want.kind, got.kind);
            compare_field("token_end", want.tok_end, got.tok_end);
            compare_field("token_line", want.line, got.line);
            compare_field("run_last", want.last, got.last);
            checked++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int src_idle_pct = 0;
    int dst_idle_pct = 0;

    tokenizer_scoreboard sb = new();

    erb_template_tokenizer_top #(
        .LINE_BITS (LINE_W)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // input transfers are noted before result transfers of the same edge
    always @(posedge clk)
    begin
        token_result_t got;
        if (s_tvalid && s_tready)
            sb.note_input(s_tuser, s_tdata);
        if (m_tvalid && m_tready)
        begin
            got.has     = m_tuser[0];
            got.data    = m_tdata[7:0];
            got.kind    = m_tuser[2:1];
            got.tok_end = m_tlast;
            got.line    = m_tdata[31:8];
            got.last    = m_tdata[32];
            sb.check_result(got);
        end
    end

    task automatic send_item(input logic act, input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_char(input logic [7:0] b);
        send_item(1'b0, b);
    endtask

    task automatic send_flush();
        send_item(1'b1, 8'($urandom_range(255)));
    endtask

    function automatic logic [7:0] rand_char(int special_pct);
        int r;
        r = $urandom_range(99);
        if (r < special_pct)
        begin
            case ($urandom_range(4))
                0: return CH_LT;
                1: return CH_PCT;
                2: return CH_EQ;
                3: return CH_GT;
                default: return CH_NL;
            endcase
        end
        if (r < special_pct + 10)
            return CH_NL;
        return 8'($urandom_range(255));
    endfunction

    // one piece of a template: text, escape, tag, flush or noise
    task automatic send_random_segment(output int n);
        int         sel;
        int         len;
        logic [7:0] b;
        n   = 0;
        sel = $urandom_range(99);
        if (sel < 30)
        begin
            len = $urandom_range(1, 5);
            repeat (len)
            begin
                do b = rand_char(10); while (b == CH_LT);
                send_char(b);
                n++;
            end
        end
        else if (sel < 40)
        begin
            send_char(CH_LT);
            send_char(CH_LT);
            n = 2;
        end
        else if (sel < 75)
        begin
            send_char(CH_LT);
            send_char(CH_PCT);
            n = 2;
            case ($urandom_range(3))
                0:
                begin
                    send_char(CH_EQ);
                    n++;
                end
                1:
                begin
                    send_char(CH_PCT);
                    n++;
                end
                default: ;
            endcase
            len = $urandom_range(0, 5);
            repeat (len)
            begin
                sel = $urandom_range(99);
                if (sel < 15)
                begin
                    send_char(CH_PCT);
                    send_char(CH_PCT);
                    n += 2;
                end
                else
                begin
                    if (sel < 25)
                    begin
                        send_char(CH_PCT);
                        n++;
                    end
                    do b = rand_char(10); while (b == CH_PCT);
                    send_char(b);
                    n++;
                end
            end
            if ($urandom_range(9) != 0)
            begin
                send_char(CH_PCT);
                send_char(CH_GT);
                n += 2;
            end
            else
            begin
                send_flush();
                n++;
            end
        end
        else if (sel < 82)
        begin
            send_flush();
            n = 1;
        end
        else
        begin
            len = $urandom_range(1, 4);
            repeat (len)
            begin
                send_char(rand_char(50));
                n++;
            end
        end
    endtask

    task automatic send_random_items(input int target);
        int sent;
        int n;
        sent = 0;
        while (sent < target)
        begin
            send_random_segment(n);
            sent += n;
        end
    endtask

    initial
    begin
        int opening[$];
        opening = '{FLUSH_ITEM, 8'h00, CH_LT, CH_LT, CH_LT, 8'hFF,
                    CH_LT, CH_PCT, CH_EQ, CH_PCT, CH_PCT, CH_PCT, 8'h78, CH_PCT, CH_GT,
                    CH_LT, CH_PCT, CH_PCT, CH_NL, CH_PCT, CH_GT,
                    8'h6B, CH_LT, FLUSH_ITEM,
                    CH_LT, CH_PCT, 8'h63, FLUSH_ITEM};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
        begin
            if (opening[i] == FLUSH_ITEM)
                send_flush();
            else
                send_char(8'(opening[i]));
        end

        src_idle_pct = 25;
        dst_idle_pct = 82;
        send_random_items(40);
        src_idle_pct = 82;
        dst_idle_pct = 25;
        send_random_items(40);
        src_idle_pct = 0;
        dst_idle_pct = 0;
        send_random_items(40);

        send_char(8'h7A);
        send_flush();
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ett_pkg.sv
rtl/ett_front.sv
rtl/ett_queue.sv
rtl/ett_back.sv
rtl/erb_template_tokenizer_top.sv
rtl/ett_checker.sv
bench/erb_template_tokenizer_top_test.sv
